### sv/ftm_pkg.sv
// Shared constants, note-frequency table and inter-stage types for the
// frequency to MIDI note converter. No dependencies.
`default_nettype none

package ftm_pkg;

  localparam int unsigned FREQ_FRAC_BITS_DEF = 8;
  localparam int unsigned FREQ_INT_BITS_DEF  = 16;

  // Internal frequency format: unsigned Q.16 hertz
  localparam int unsigned Q_FRAC = 16;

  // Table covers notes -1..128; every entry stays below 2^NOTE_W
  localparam int unsigned NUM_NOTES = 130;
  localparam int unsigned NOTE_W    = 30;
  localparam int unsigned CNT_W     = $clog2(NUM_NOTES + 1);
  localparam int unsigned IDX_W     = $clog2(NUM_NOTES);

  localparam int unsigned MIDI_W = 7;
  localparam int unsigned BEND_W = 6;
  localparam logic [MIDI_W-1:0] NOTE_MAX = MIDI_W'(127);

  // Bend = floor((BEND_SCALE*d + g) / (2*g)), with d < g < 2^NOTE_W
  localparam int unsigned BEND_SCALE = 200;
  localparam int unsigned NUM_W      = NOTE_W + 8;
  localparam int unsigned DEN_W      = NOTE_W + 1;

  localparam int unsigned SEMITONES   = 12;
  localparam int unsigned TOP_OCTAVE  = 11;
  localparam logic [63:0] UHZ_PER_HZ  = 64'd1000000;

  // Notes 120..131 in microhertz
  localparam logic [63:0] TOP_UHZ [SEMITONES] = '{
    64'd8372018090,  64'd8869844191,  64'd9397272573,  64'd9956063479,
    64'd10548081821, 64'd11175303406, 64'd11839821527, 64'd12543853951,
    64'd13289750323, 64'd14080000000, 64'd14917240368, 64'd15804265640
  };

  typedef logic [NOTE_W-1:0] note_tbl_t [NUM_NOTES];

  // Entry i is note i-1 in Q.16, rounded half up. Nested floors let the
  // octave shift come after the divide by a fixed constant.
  function automatic note_tbl_t build_note_tbl();
    note_tbl_t   tbl;
    logic [63:0] num;
    logic [63:0] half;
    int unsigned m;
    int unsigned sh;
    for (int unsigned i = 0; i < NUM_NOTES; i++) begin
      m      = i + SEMITONES - 1;
      sh     = TOP_OCTAVE - m / SEMITONES;
      num    = TOP_UHZ[m % SEMITONES] << Q_FRAC;
      half   = (UHZ_PER_HZ >> 1) << sh;
      tbl[i] = NOTE_W'(((num + half) / UHZ_PER_HZ) >> sh);
    end
    return tbl;
  endfunction

  localparam note_tbl_t NOTE_TBL = build_note_tbl();

  // Request into the bend divider; rem starts as the dividend
  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [MIDI_W-1:0] note;
    logic              down;
    logic              flag;
    logic              zero_bend;
  } div_req_t;

endpackage

`default_nettype wire

### sv/ftm_search.sv
// Pipelined binary search: counts note-table entries at or below the
// frequency, one count bit per stage. Uses ftm_pkg (NOTE_TBL, widths).
`default_nettype none

module ftm_search #(
  parameter int unsigned FS_W = 40
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [FS_W-1:0]           fs_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [FS_W-1:0]           fs_o,
  output logic [ftm_pkg::CNT_W-1:0] cnt_o
);
  import ftm_pkg::*;

  logic [CNT_W:0]   v_s;
  logic [CNT_W:0]   rdy;
  logic [FS_W-1:0]  fs_s  [CNT_W+1];
  logic [CNT_W-1:0] cnt_s [CNT_W+1];

  assign v_s[0]     = in_valid_i;
  assign fs_s[0]    = fs_i;
  assign cnt_s[0]   = '0;
  assign rdy[CNT_W] = out_ready_i;

  for (genvar k = 0; k < CNT_W; k++) begin : g_stage
    localparam int unsigned B = CNT_W - 1 - k;

    logic             v_q;
    logic [FS_W-1:0]  fs_q;
    logic [CNT_W-1:0] cnt_q;
    logic [CNT_W-1:0] cand;
    logic [IDX_W-1:0] idx;
    logic             in_tbl;
    logic             take;

    // A stage moves when it is empty or its successor moves
    assign rdy[k]  = !v_q || rdy[k+1];
    assign cand    = cnt_s[k] | (CNT_W'(1) << B);
    assign in_tbl  = cand <= CNT_W'(NUM_NOTES);
    assign idx     = in_tbl ? IDX_W'(cand - CNT_W'(1)) : '0;
    assign take    = in_tbl && (FS_W'(NOTE_TBL[idx]) <= fs_s[k]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (rdy[k]) begin
        v_q <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_s[k]) begin
        fs_q  <= fs_s[k];
        cnt_q <= take ? cand : cnt_s[k];
      end
    end

    assign v_s[k+1]   = v_q;
    assign fs_s[k+1]  = fs_q;
    assign cnt_s[k+1] = cnt_q;
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_s[CNT_W];
  assign fs_o        = fs_s[CNT_W];
  assign cnt_o       = cnt_s[CNT_W];

endmodule

`default_nettype wire

### sv/ftm_pick.sv
// Neighbor fetch, geometric-midpoint products and note choice; builds the
// divider request for the bend. Uses ftm_pkg (NOTE_TBL, div_req_t).
`default_nettype none

module ftm_pick #(
  parameter int unsigned FS_W = 40
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [FS_W-1:0]           fs_i,
  input  logic [ftm_pkg::CNT_W-1:0] cnt_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output ftm_pkg::div_req_t         req_o
);
  import ftm_pkg::*;

  // Fetch stage
  logic              a_v_q;
  logic [NOTE_W-1:0] a_fs_q, a_lo_q, a_hi_q;
  logic [CNT_W-1:0]  a_cnt_q;
  logic              a_below_q, a_above_q;
  // Multiply stage
  logic                b_v_q;
  logic [NOTE_W-1:0]   b_fs_q, b_lo_q, b_hi_q;
  logic [CNT_W-1:0]    b_cnt_q;
  logic                b_below_q, b_above_q;
  logic [2*NOTE_W-1:0] b_sq_q, b_prod_q;
  // Select stage
  logic     c_v_q;
  div_req_t c_req_q, c_req_d;

  logic             rdy_a, rdy_b, rdy_c;
  logic [IDX_W-1:0] lo_idx, hi_idx;

  assign rdy_c      = !c_v_q || out_ready_i;
  assign rdy_b      = !b_v_q || rdy_c;
  assign rdy_a      = !a_v_q || rdy_b;
  assign in_ready_o = rdy_a;

  assign lo_idx = (cnt_i == '0) ? '0 : IDX_W'(cnt_i - CNT_W'(1));
  assign hi_idx = (cnt_i >= CNT_W'(NUM_NOTES)) ? IDX_W'(NUM_NOTES - 1) : IDX_W'(cnt_i);

  always_comb begin
    logic              upper;
    logic              low_clamp;
    logic              high_clamp;
    logic              flag;
    logic [NOTE_W-1:0] gap;
    logic [NOTE_W-1:0] delta;
    logic [CNT_W-1:0]  chosen;
    upper      = b_sq_q >= b_prod_q;
    // Nearest note under 0 or over 127 clamps and raises the flag
    low_clamp  = b_below_q || ((b_cnt_q == CNT_W'(1)) && !upper);
    high_clamp = b_above_q || ((b_cnt_q == CNT_W'(NUM_NOTES - 1)) && upper);
    flag       = low_clamp || high_clamp;
    gap        = b_hi_q - b_lo_q;
    delta      = upper ? (b_hi_q - b_fs_q) : (b_fs_q - b_lo_q);
    chosen     = b_cnt_q + CNT_W'(upper) - CNT_W'(2);

    c_req_d.zero_bend = flag || (b_fs_q == b_lo_q) || (gap == '0);
    c_req_d.flag      = flag;
    c_req_d.down      = upper && !c_req_d.zero_bend;
    c_req_d.rem       = NUM_W'(delta) * NUM_W'(BEND_SCALE) + NUM_W'(gap);
    c_req_d.den       = DEN_W'(gap) << 1;
    priority if (low_clamp) begin
      c_req_d.note = '0;
    end else if (high_clamp) begin
      c_req_d.note = NOTE_MAX;
    end else begin
      c_req_d.note = MIDI_W'(chosen);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (rdy_a) a_v_q <= in_valid_i;
      if (rdy_b) b_v_q <= a_v_q;
      if (rdy_c) c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      // In range the frequency lies below the top entry, so it fits NOTE_W
      a_fs_q    <= NOTE_W'(fs_i);
      a_lo_q    <= NOTE_TBL[lo_idx];
      a_hi_q    <= NOTE_TBL[hi_idx];
      a_cnt_q   <= cnt_i;
      a_below_q <= cnt_i == '0;
      a_above_q <= cnt_i == CNT_W'(NUM_NOTES);
    end
    if (rdy_b && a_v_q) begin
      b_fs_q    <= a_fs_q;
      b_lo_q    <= a_lo_q;
      b_hi_q    <= a_hi_q;
      b_cnt_q   <= a_cnt_q;
      b_below_q <= a_below_q;
      b_above_q <= a_above_q;
      b_sq_q    <= (2*NOTE_W)'(a_fs_q) * (2*NOTE_W)'(a_fs_q);
      b_prod_q  <= (2*NOTE_W)'(a_lo_q) * (2*NOTE_W)'(a_hi_q);
    end
    if (rdy_c && b_v_q) begin
      c_req_q <= c_req_d;
    end
  end

  assign out_valid_o = c_v_q;
  assign req_o       = c_req_q;

endmodule

`default_nettype wire

### sv/ftm_div.sv
// Pipelined restoring divider for the bend percent, one quotient bit per
// stage. Uses ftm_pkg (div_req_t, widths).
`default_nettype none

module ftm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ftm_pkg::div_req_t          req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ftm_pkg::MIDI_W-1:0] note_o,
  output logic [ftm_pkg::BEND_W-1:0] bend_o,
  output logic                       down_o,
  output logic                       flag_o
);
  import ftm_pkg::*;

  logic [BEND_W:0]   v_s;
  logic [BEND_W:0]   rdy;
  div_req_t          req_s [BEND_W+1];
  logic [BEND_W-1:0] quo_s [BEND_W+1];

  assign v_s[0]      = in_valid_i;
  assign req_s[0]    = req_i;
  assign quo_s[0]    = '0;
  assign rdy[BEND_W] = out_ready_i;

  for (genvar k = 0; k < BEND_W; k++) begin : g_stage
    localparam int unsigned B = BEND_W - 1 - k;

    logic              v_q;
    div_req_t          req_q;
    logic [BEND_W-1:0] quo_q;
    logic [NUM_W-1:0]  sub;
    logic              fits;
    div_req_t          req_d;

    assign rdy[k] = !v_q || rdy[k+1];
    assign sub    = NUM_W'(req_s[k].den) << B;
    assign fits   = req_s[k].rem >= sub;

    always_comb begin
      req_d = req_s[k];
      if (fits) req_d.rem = req_s[k].rem - sub;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (rdy[k]) begin
        v_q <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_s[k]) begin
        req_q <= req_d;
        quo_q <= quo_s[k] | (BEND_W'(fits) << B);
      end
    end

    assign v_s[k+1]   = v_q;
    assign req_s[k+1] = req_q;
    assign quo_s[k+1] = quo_q;
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_s[BEND_W];
  assign note_o      = req_s[BEND_W].note;
  assign down_o      = req_s[BEND_W].down;
  assign flag_o      = req_s[BEND_W].flag;
  // Drop the quotient for exact notes and clamped results
  assign bend_o      = req_s[BEND_W].zero_bend ? '0 : quo_s[BEND_W];

endmodule

`default_nettype wire

### sv/freq_to_midi_note_bend.sv
// Top level: frequency to nearest MIDI note with pitch bend.
// Uses ftm_pkg, ftm_search, ftm_pick and ftm_div.
//
//   channel | handshake                | payload
//   --------+--------------------------+-------------------------------------
//   input   | in_valid_i / in_ready_o  | frequency_q8_i
//   output  | out_valid_o / out_ready_i| note_number_o, bend_percent_o,
//           |                          | bend_down_o, out_of_range_o
//
// One request per cycle sustained while the output is not stalled. The
// pipeline has 8 binary-search stages over the 130-entry note table, fetch,
// multiply and select stages, then 6 divider stages, one per bend bit.
// Reset clears only the stage valid bits; nothing else needs clearing.
// A stalled output holds the last stage; earlier stages keep moving into
// empty slots, so input is taken until every stage is full.
`default_nettype none

module freq_to_midi_note_bend #(
  parameter int unsigned FREQ_FRAC_BITS = ftm_pkg::FREQ_FRAC_BITS_DEF,
  parameter int unsigned FREQ_INT_BITS  = ftm_pkg::FREQ_INT_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [FREQ_INT_BITS+FREQ_FRAC_BITS-1:0] frequency_q8_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [ftm_pkg::MIDI_W-1:0]            note_number_o,
  output logic [ftm_pkg::BEND_W-1:0]            bend_percent_o,
  output logic                                  bend_down_o,
  output logic                                  out_of_range_o
);
  import ftm_pkg::*;

  localparam int unsigned FS_W     = FREQ_INT_BITS + Q_FRAC;
  localparam int unsigned FS_SHIFT = Q_FRAC - FREQ_FRAC_BITS;

  logic             fs_in_ready;
  logic [FS_W-1:0]  fs;
  logic             srch_valid, srch_ready;
  logic [FS_W-1:0]  srch_fs;
  logic [CNT_W-1:0] srch_cnt;
  logic             pick_valid, pick_ready;
  div_req_t         pick_req;

  // Align to Q.16 hertz
  assign fs         = FS_W'(frequency_q8_i) << FS_SHIFT;
  assign in_ready_o = fs_in_ready;

  ftm_search #(
    .FS_W(FS_W)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (fs_in_ready),
    .fs_i       (fs),
    .out_valid_o(srch_valid),
    .out_ready_i(srch_ready),
    .fs_o       (srch_fs),
    .cnt_o      (srch_cnt)
  );

  ftm_pick #(
    .FS_W(FS_W)
  ) u_pick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (srch_valid),
    .in_ready_o (srch_ready),
    .fs_i       (srch_fs),
    .cnt_i      (srch_cnt),
    .out_valid_o(pick_valid),
    .out_ready_i(pick_ready),
    .req_o      (pick_req)
  );

  ftm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pick_valid),
    .in_ready_o (pick_ready),
    .req_i      (pick_req),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .note_o     (note_number_o),
    .bend_o     (bend_percent_o),
    .down_o     (bend_down_o),
    .flag_o     (out_of_range_o)
  );

`ifndef NO_ASSERTIONS
  // Input backpressure only comes from a full pipeline behind a stalled output
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  a_flag_no_bend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (bend_percent_o == '0 && !bend_down_o))
    else $error("out-of-range result carries a bend");

  a_flag_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |->
      (note_number_o == '0 || note_number_o == NOTE_MAX))
    else $error("out-of-range note not clamped");

  a_bend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bend_percent_o <= BEND_W'(51)))
    else $error("bend beyond half the semitone gap");
`endif

endmodule

`default_nettype wire
